// ----- hw/rtl/glk_pkg.sv -----
package glk_pkg;

    // default number of glyphs in a font
    localparam int GLYPH_COUNT_DEF = 256;

    // queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    // wide enough for the queue fill plus the two front stages
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 3);

    // metric entry with kern and advance both -1
    localparam logic [15:0] MISSING_METRIC = 16'hFFFF;

    // request kinds
    typedef enum logic [1:0] {
        FUNC_LOAD_OFFSET = 2'd0,
        FUNC_LOAD_METRIC = 2'd1,
        FUNC_START       = 2'd2,
        FUNC_CHAR        = 2'd3
    } func_t;

    // font kinds; the last one places glyphs but leaves the pen alone
    typedef enum logic [1:0] {
        KIND_STRIP  = 2'd0,
        KIND_FIXED  = 2'd1,
        KIND_KERN   = 2'd2,
        KIND_FROZEN = 2'd3
    } kind_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_FONT_KIND     = 3'd0,
        REG_FIRST_CODE    = 3'd1,
        REG_LAST_CODE     = 3'd2,
        REG_FIXED_ADVANCE = 3'd3,
        REG_KERN_BIAS     = 3'd4,
        REG_STRIP_BYTES   = 3'd5
    } reg_index_t;

    typedef struct packed {
        kind_t              font_kind;
        logic [7:0]         first_code;
        logic [7:0]         last_code;
        logic [7:0]         fixed_advance;
        logic signed [8:0]  kern_bias;
        logic [12:0]        strip_bytes;
    } glk_cfg_t;

    // one classified request on its way to the back
    typedef struct packed {
        logic               is_start;
        logic [15:0]        x;          // start x, or glyph source x
        logic [15:0]        y;          // start y
        logic signed [16:0] width;
        logic               missing;
        logic               kern_glyph; // present glyph of a kerning font
        logic signed [9:0]  kern_add;   // glyph kern plus bias
        logic signed [16:0] advance;
    } glk_op_t;

    // queue status seen by both sides
    typedef struct packed {
        logic              valid;
        glk_op_t           head;
        logic [QCNT_W-1:0] count;
    } glk_qstat_t;

    // clamp to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/glk_front.sv -----
module glk_front #(
    parameter int GLYPH_COUNT = glk_pkg::GLYPH_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  glk_pkg::glk_cfg_t   cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          func,
    input  logic [8:0]          entry_index,
    input  logic [15:0]         offset_value,
    input  logic signed [7:0]   kern_value,
    input  logic signed [7:0]   advance_value,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    input  logic [7:0]          char_code,
    input  glk_pkg::glk_qstat_t qstat,
    output logic                push,
    output glk_pkg::glk_op_t    push_op
);

    localparam int MA = $clog2(GLYPH_COUNT);
    localparam int OA = $clog2(GLYPH_COUNT + 1);
    localparam logic [8:0] GC = 9'(GLYPH_COUNT);

    logic [15:0] metric_mem [GLYPH_COUNT];
    logic [15:0] offset_mem [GLYPH_COUNT + 1];

    logic                  accept;
    logic [glk_pkg::QCNT_W-1:0] busy;
    logic [7:0]            c_in;
    logic                  metric_ok_in;

    // stage a registers
    logic                  a_valid_reg;
    glk_pkg::func_t        a_func_reg;
    logic [7:0]            a_c_reg;
    logic [8:0]            a_idx_reg;
    logic [15:0]           a_offset_reg;
    logic [15:0]           a_start_x_reg;
    logic [15:0]           a_start_y_reg;
    logic                  a_metric_ok_reg;
    logic [15:0]           a_metric_reg;

    // stage b signals and registers
    logic [15:0]           metric;
    logic                  a_char;
    logic                  missing;
    logic [7:0]            fallback;
    logic [8:0]            addr0;
    logic [8:0]            addr1;
    logic                  ok0;
    logic                  ok1;
    logic                  b_valid_reg;
    logic                  b_is_start_reg;
    logic                  b_missing_reg;
    logic                  b_ok0_reg;
    logic                  b_ok1_reg;
    logic [15:0]           b_metric_reg;
    logic [15:0]           b_start_x_reg;
    logic [15:0]           b_start_y_reg;
    logic [15:0]           b_rd0_reg;
    logic [15:0]           b_rd1_reg;

    // stage c signals
    logic [15:0]           off0;
    logic [15:0]           off1;
    logic [15:0]           strip_px;
    logic signed [16:0]    width;
    logic signed [16:0]    adv_ext;
    logic signed [16:0]    advance;

    // accept only while the queue can hold everything in flight
    assign busy = qstat.count + glk_pkg::QCNT_W'(a_valid_reg)
                + glk_pkg::QCNT_W'(b_valid_reg);
    assign item_ready = busy < glk_pkg::QCNT_W'(glk_pkg::QUEUE_DEPTH);
    assign accept = item_valid && item_ready;

    // rebase the character code
    assign c_in = char_code - cfg.first_code;
    assign metric_ok_in = {1'b0, c_in} < GC;

    // stage a control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    // stage a payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_func_reg      <= glk_pkg::func_t'(func);
            a_c_reg         <= c_in;
            a_idx_reg       <= entry_index;
            a_offset_reg    <= offset_value;
            a_start_x_reg   <= start_x;
            a_start_y_reg   <= start_y;
            a_metric_ok_reg <= metric_ok_in;
        end
    end

    // metric table: load write and character read at acceptance
    always_ff @(posedge clk)
    begin
        if (accept && func == glk_pkg::FUNC_LOAD_METRIC && entry_index < GC)
        begin
            metric_mem[entry_index[MA-1:0]] <= {kern_value, advance_value};
        end
        if (accept && func == glk_pkg::FUNC_CHAR && metric_ok_in)
        begin
            a_metric_reg <= metric_mem[c_in[MA-1:0]];
        end
    end

    // classify and pick offset addresses
    assign metric   = a_metric_ok_reg ? a_metric_reg : 16'h0000;
    assign a_char   = a_func_reg == glk_pkg::FUNC_CHAR;
    assign missing  = a_char && cfg.font_kind == glk_pkg::KIND_KERN
                    && metric == glk_pkg::MISSING_METRIC;
    assign fallback = cfg.last_code - cfg.first_code;
    assign addr0    = {1'b0, a_c_reg};
    assign addr1    = missing ? ({1'b0, fallback} + 9'd1) : ({1'b0, a_c_reg} + 9'd1);
    assign ok0      = addr0 <= GC;
    assign ok1      = addr1 <= GC;

    // offset table: load write and two character reads in order with stage b
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && a_func_reg == glk_pkg::FUNC_LOAD_OFFSET && a_idx_reg <= GC)
        begin
            offset_mem[a_idx_reg[OA-1:0]] <= a_offset_reg;
        end
        if (a_valid_reg && a_char && ok0)
        begin
            b_rd0_reg <= offset_mem[addr0[OA-1:0]];
        end
        if (a_valid_reg && a_char && ok1)
        begin
            b_rd1_reg <= offset_mem[addr1[OA-1:0]];
        end
    end

    // stage b control: only starts and characters go on to the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg && (a_char || a_func_reg == glk_pkg::FUNC_START);
        end
    end

    // stage b payload
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_is_start_reg <= a_func_reg == glk_pkg::FUNC_START;
            b_missing_reg  <= missing;
            b_ok0_reg      <= ok0;
            b_ok1_reg      <= ok1;
            b_metric_reg   <= metric;
            b_start_x_reg  <= a_start_x_reg;
            b_start_y_reg  <= a_start_y_reg;
        end
    end

    // glyph width and pen advance
    assign off0     = b_ok0_reg ? b_rd0_reg : 16'h0000;
    assign off1     = b_ok1_reg ? b_rd1_reg : 16'h0000;
    assign strip_px = {cfg.strip_bytes, 3'b000};
    assign width    = b_missing_reg ? ($signed({1'b0, strip_px}) - $signed({1'b0, off1}))
                                    : ($signed({1'b0, off1}) - $signed({1'b0, off0}));
    assign adv_ext  = {{9{b_metric_reg[7]}}, b_metric_reg[7:0]};

    always_comb
    begin
        case (cfg.font_kind)
            glk_pkg::KIND_STRIP: advance = width;
            glk_pkg::KIND_FIXED: advance = {9'b0, cfg.fixed_advance};
            glk_pkg::KIND_KERN:  advance = b_missing_reg ? width : adv_ext;
            default:             advance = 17'sd0;
        endcase
    end

    // queue entry
    always_comb
    begin
        push_op.is_start   = b_is_start_reg;
        push_op.x          = b_is_start_reg ? b_start_x_reg
                                            : (b_missing_reg ? off1 : off0);
        push_op.y          = b_start_y_reg;
        push_op.width      = width;
        push_op.missing    = b_missing_reg;
        push_op.kern_glyph = cfg.font_kind == glk_pkg::KIND_KERN && !b_missing_reg;
        push_op.kern_add   = {{2{b_metric_reg[15]}}, b_metric_reg[15:8]}
                           + {cfg.kern_bias[8], cfg.kern_bias};
        push_op.advance    = advance;
    end

    assign push = b_valid_reg;

endmodule

// ----- hw/rtl/glk_queue.sv -----
module glk_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  glk_pkg::glk_op_t    push_op,
    input  logic                pop,
    output glk_pkg::glk_qstat_t qstat
);

    glk_pkg::glk_op_t                  entries [glk_pkg::QUEUE_DEPTH];
    logic [glk_pkg::QUEUE_AW-1:0]      head_reg;
    logic [glk_pkg::QUEUE_AW-1:0]      tail_reg;
    logic [glk_pkg::QCNT_W-1:0]        count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[tail_reg] <= push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // status toward both sides
    assign qstat.valid = count_reg != '0;
    assign qstat.head  = entries[head_reg];
    assign qstat.count = count_reg;

endmodule

// ----- hw/rtl/glk_back.sv -----
module glk_back (
    input  logic                clk,
    input  logic                rst_n,
    input  glk_pkg::glk_qstat_t qstat,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [15:0]         source_x,
    output logic signed [16:0]  glyph_width,
    output logic signed [15:0]  dest_x,
    output logic signed [15:0]  dest_y,
    output logic                glyph_missing
);

    glk_pkg::glk_op_t   op;
    logic               can_out;
    logic signed [17:0] kern_sum;
    logic signed [15:0] kerned;
    logic signed [17:0] adv_sum;

    logic signed [15:0] pen_x_reg;
    logic signed [15:0] pen_x_next;
    logic signed [15:0] pen_y_reg;
    logic signed [15:0] pen_y_next;
    logic               pending_reg;
    logic               pending_next;
    logic               result_valid_reg;
    logic [15:0]        source_x_reg;
    logic signed [16:0] glyph_width_reg;
    logic signed [15:0] dest_x_reg;
    logic signed [15:0] dest_y_reg;
    logic               glyph_missing_reg;

    assign op = qstat.head;

    // take the head when the output register is free, starts need no slot
    assign can_out = !result_valid_reg || result_ready;
    assign pop     = qstat.valid && (op.is_start || can_out);

    // kern of this glyph, then the pen advance
    assign kern_sum = {{2{pen_x_reg[15]}}, pen_x_reg} + {{8{op.kern_add[9]}}, op.kern_add};
    assign kerned   = (pending_reg && op.kern_glyph) ? glk_pkg::sat16(kern_sum) : pen_x_reg;
    assign adv_sum  = {{2{kerned[15]}}, kerned} + {op.advance[16], op.advance};

    assign pen_x_next   = op.is_start ? op.x : glk_pkg::sat16(adv_sum);
    assign pen_y_next   = op.is_start ? op.y : pen_y_reg;
    assign pending_next = !op.is_start && op.kern_glyph;

    // pen state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg        <= '0;
            pen_y_reg        <= '0;
            pending_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pen_x_reg   <= pen_x_next;
                pen_y_reg   <= pen_y_next;
                pending_reg <= pending_next;
            end
            if (pop && !op.is_start)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop && !op.is_start)
        begin
            source_x_reg      <= op.x;
            glyph_width_reg   <= op.width;
            dest_x_reg        <= kerned;
            dest_y_reg        <= pen_y_reg;
            glyph_missing_reg <= op.missing;
        end
    end

    assign result_valid  = result_valid_reg;
    assign source_x      = source_x_reg;
    assign glyph_width   = glyph_width_reg;
    assign dest_x        = dest_x_reg;
    assign dest_y        = dest_y_reg;
    assign glyph_missing = glyph_missing_reg;

endmodule

// ----- hw/rtl/glyph_layout_with_kerning.sv -----
// channel   | handshake                   | payload
// ----------+-----------------------------+----------------------------------------------
// config    | psel penable pwrite pready  | paddr pwdata, prdata on reads
// item      | item_valid item_ready       | func entry_index offset_value kern_value
//           |                             | advance_value start_x start_y char_code
// result    | result_valid result_ready   | source_x glyph_width dest_x dest_y glyph_missing
//
// one request per cycle while item_ready holds; a character result passes through the metric
// read, the offset read, the queue and the output register before it shows on result_valid.
// the pen loop in the back (kern add then advance add, both saturating) sets the rate.
// reset clears the pen and the queue and puts config back to its defaults;
// glyph tables hold garbage until loaded.
// item_ready drops once the queue plus the two front stages would overfill; a stalled
// result only holds back the back side while the front keeps filling the queue.
module glyph_layout_with_kerning #(
    parameter int GLYPH_COUNT = glk_pkg::GLYPH_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         func,
    input  logic [8:0]         entry_index,
    input  logic [15:0]        offset_value,
    input  logic signed [7:0]  kern_value,
    input  logic signed [7:0]  advance_value,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic [7:0]         char_code,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [15:0]        source_x,
    output logic signed [16:0] glyph_width,
    output logic signed [15:0] dest_x,
    output logic signed [15:0] dest_y,
    output logic               glyph_missing
);

    glk_pkg::glk_cfg_t   cfg_reg;
    glk_pkg::reg_index_t reg_sel;
    logic                cfg_write;
    logic                q_push;
    logic                q_pop;
    glk_pkg::glk_op_t    q_push_op;
    glk_pkg::glk_qstat_t q_stat;

    // register write port
    assign pready    = 1'b1;
    assign reg_sel   = glk_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.font_kind     <= glk_pkg::KIND_STRIP;
            cfg_reg.first_code    <= 8'd32;
            cfg_reg.last_code     <= 8'd127;
            cfg_reg.fixed_advance <= 8'd8;
            cfg_reg.kern_bias     <= '0;
            cfg_reg.strip_bytes   <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                glk_pkg::REG_FONT_KIND:     cfg_reg.font_kind     <= glk_pkg::kind_t'(pwdata[1:0]);
                glk_pkg::REG_FIRST_CODE:    cfg_reg.first_code    <= pwdata[7:0];
                glk_pkg::REG_LAST_CODE:     cfg_reg.last_code     <= pwdata[7:0];
                glk_pkg::REG_FIXED_ADVANCE: cfg_reg.fixed_advance <= pwdata[7:0];
                glk_pkg::REG_KERN_BIAS:     cfg_reg.kern_bias     <= pwdata[8:0];
                glk_pkg::REG_STRIP_BYTES:   cfg_reg.strip_bytes   <= pwdata[12:0];
                default:                    ;
            endcase
        end
    end

    // register read port
    always_comb
    begin
        case (reg_sel)
            glk_pkg::REG_FONT_KIND:     prdata = {30'b0, cfg_reg.font_kind};
            glk_pkg::REG_FIRST_CODE:    prdata = {24'b0, cfg_reg.first_code};
            glk_pkg::REG_LAST_CODE:     prdata = {24'b0, cfg_reg.last_code};
            glk_pkg::REG_FIXED_ADVANCE: prdata = {24'b0, cfg_reg.fixed_advance};
            glk_pkg::REG_KERN_BIAS:     prdata = 32'(cfg_reg.kern_bias);
            glk_pkg::REG_STRIP_BYTES:   prdata = {19'b0, cfg_reg.strip_bytes};
            default:                    prdata = 32'b0;
        endcase
    end

    // front: accept, table access, classification
    glk_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .entry_index   (entry_index),
        .offset_value  (offset_value),
        .kern_value    (kern_value),
        .advance_value (advance_value),
        .start_x       (start_x),
        .start_y       (start_y),
        .char_code     (char_code),
        .qstat         (q_stat),
        .push          (q_push),
        .push_op       (q_push_op)
    );

    // decoupling queue
    glk_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .qstat   (q_stat)
    );

    // back: pen update and result register
    glk_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (q_stat),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .source_x      (source_x),
        .glyph_width   (glyph_width),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .glyph_missing (glyph_missing)
    );

`ifndef SYNTHESIS
    // queue never written past full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> q_stat.count < glk_pkg::QCNT_W'(glk_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

    // back only pops a filled queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("queue underflow");

    // a held result is never overwritten by a character
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !(q_pop && !q_stat.head.is_start))
        else $error("result overwritten while stalled");

    // an accepted request always finds room in the queue
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> q_stat.count < glk_pkg::QCNT_W'(glk_pkg::QUEUE_DEPTH))
        else $error("request accepted without queue room");
`endif

endmodule

// ----- tb/glyph_layout_with_kerning_test.sv -----
`timescale 1ns / 1ps

package glyph_layout_test_pkg;

    import glk_pkg::*;

    // one request as seen on the item channel
    typedef struct {
        func_t              func;
        logic [8:0]         entry;
        logic [15:0]        offset;
        logic signed [7:0]  kern;
        logic signed [7:0]  advance;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic [7:0]         code;
    } glyph_req_t;

    // one placed glyph as seen on the result channel
    typedef struct {
        logic [15:0]        source_x;
        logic signed [16:0] glyph_width;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic               glyph_missing;
    } glyph_place_t;

    class glyph_scoreboard;

        // font registers as the block should hold them
        kind_t              kind;
        logic [7:0]         first_code;
        logic [7:0]         last_code;
        logic [7:0]         fixed_advance;
        logic signed [8:0]  kern_bias;
        logic [12:0]        strip_bytes;

        // glyph tables and pen
        logic [15:0]        offsets [0:256];
        logic [15:0]        metrics [0:255];
        int                 pen_x;
        int                 pen_y;
        bit                 kern_armed;

        glyph_place_t       expected_places [$];
        int                 errors;

        function new();
            kind          = KIND_STRIP;
            first_code    = 8'd32;
            last_code     = 8'd127;
            fixed_advance = 8'd8;
            kern_bias     = '0;
            strip_bytes   = '0;
            pen_x         = 0;
            pen_y         = 0;
            kern_armed    = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return expected_places.size();
        endfunction

        // pen x is clamped to the signed 16-bit range after every add
        function int clamp_pen(int v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        function void set_reg(reg_index_t r, logic [31:0] v);
            case (r)
                REG_FONT_KIND:     kind = kind_t'(v[1:0]);
                REG_FIRST_CODE:    first_code = v[7:0];
                REG_LAST_CODE:     last_code = v[7:0];
                REG_FIXED_ADVANCE: fixed_advance = v[7:0];
                REG_KERN_BIAS:     kern_bias = v[8:0];
                REG_STRIP_BYTES:   strip_bytes = v[12:0];
                default: ;
            endcase
        endfunction

        // where a character lands, and how the pen moves on
        function glyph_place_t place_glyph(logic [7:0] code);
            logic [7:0]   slot;
            logic [7:0]   fallback;
            logic [15:0]  metric;
            logic [15:0]  src;
            int           width;
            bit           armed;
            bit           gone;
            glyph_place_t p;
            slot   = code - first_code;
            metric = metrics[slot];
            armed  = kern_armed;
            kern_armed = 1'b0;
            gone   = (kind == KIND_KERN) && (metric == MISSING_METRIC);

            // kern of this glyph moves the pen before placing it
            if (kind == KIND_KERN && armed && !gone)
            begin
                pen_x = clamp_pen(pen_x + int'($signed(metric[15:8])) + int'(kern_bias));
            end

            // missing glyph takes the span after the last glyph, running to the strip end
            if (gone)
            begin
                fallback = last_code - first_code;
                src   = offsets[int'(fallback) + 1];
                width = int'(strip_bytes) * 8 - int'(src);
            end
            else
            begin
                src   = offsets[slot];
                width = int'(offsets[int'(slot) + 1]) - int'(src);
            end

            p.source_x      = src;
            p.glyph_width   = 17'(width);
            p.dest_x        = pen_x[15:0];
            p.dest_y        = pen_y[15:0];
            p.glyph_missing = gone;

            // pen advance per font kind; the frozen kind leaves it alone
            case (kind)
                KIND_STRIP: pen_x = clamp_pen(pen_x + width);
                KIND_FIXED: pen_x = clamp_pen(pen_x + int'(fixed_advance));
                KIND_KERN:
                begin
                    if (gone)
                    begin
                        pen_x = clamp_pen(pen_x + width);
                    end
                    else
                    begin
                        pen_x = clamp_pen(pen_x + int'($signed(metric[7:0])));
                        kern_armed = 1'b1;
                    end
                end
                default: ;
            endcase
            return p;
        endfunction

        function void note_request(glyph_req_t rq);
            case (rq.func)
                FUNC_LOAD_OFFSET:
                begin
                    if (rq.entry <= 9'd256)
                    begin
                        offsets[rq.entry] = rq.offset;
                    end
                end
                FUNC_LOAD_METRIC:
                begin
                    if (rq.entry < 9'd256)
                    begin
                        metrics[rq.entry[7:0]] = {rq.kern, rq.advance};
                    end
                end
                FUNC_START:
                begin
                    pen_x = rq.pen_x;
                    pen_y = rq.pen_y;
                    kern_armed = 1'b0;
                end
                default: expected_places.push_back(place_glyph(rq.code));
            endcase
        endfunction

        task report(string what);
            errors++;
            // keep the log short when something breaks badly
            if (errors <= 50)
            begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endtask

        task compare_field(string name, logic signed [31:0] got, logic signed [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s is %0d, expected %0d", name, got, want));
            end
        endtask

        task check_result(glyph_place_t got);
            glyph_place_t want;
            if (expected_places.size() == 0)
            begin
                report($sformatf("glyph at x %0d y %0d with no character pending",
                                 got.dest_x, got.dest_y));
            end
            else
            begin
                want = expected_places.pop_front();
                compare_field("source_x", got.source_x, want.source_x);
                compare_field("glyph_width", got.glyph_width, want.glyph_width);
                compare_field("dest_x", got.dest_x, want.dest_x);
                compare_field("dest_y", got.dest_y, want.dest_y);
                compare_field("glyph_missing", got.glyph_missing, want.glyph_missing);
            end
        endtask

    endclass

endpackage

module glyph_layout_with_kerning_test;

    import glk_pkg::*;
    import glyph_layout_test_pkg::*;

    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQUESTS = 20;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic [1:0]         func = '0;
    logic [8:0]         entry_index = '0;
    logic [15:0]        offset_value = '0;
    logic signed [7:0]  kern_value = '0;
    logic signed [7:0]  advance_value = '0;
    logic signed [15:0] start_x = '0;
    logic signed [15:0] start_y = '0;
    logic [7:0]         char_code = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [15:0]        source_x;
    logic signed [16:0] glyph_width;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic               glyph_missing;

    glyph_scoreboard    places;
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 stall_left = 0;
    int                 idle_cycles = 0;

    glyph_layout_with_kerning dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .entry_index  (entry_index),
        .offset_value (offset_value),
        .kern_value   (kern_value),
        .advance_value(advance_value),
        .start_x      (start_x),
        .start_y      (start_y),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .source_x     (source_x),
        .glyph_width  (glyph_width),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .glyph_missing(glyph_missing)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rst_n && $urandom_range(0, 99) < stall_pct)
        begin
            result_ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // watch both channels
    always @(posedge clk)
    begin
        glyph_req_t rq;
        if (rst_n && item_valid && item_ready)
        begin
            rq.func    = func_t'(func);
            rq.entry   = entry_index;
            rq.offset  = offset_value;
            rq.kern    = kern_value;
            rq.advance = advance_value;
            rq.pen_x   = start_x;
            rq.pen_y   = start_y;
            rq.code    = char_code;
            places.note_request(rq);
        end
        if (rst_n && result_valid && result_ready)
        begin
            places.check_result('{source_x, glyph_width, dest_x, dest_y, glyph_missing});
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic int pick_value(int lo, int hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            return lo;
        end
        if (r == 1)
        begin
            return hi;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // every field random; callers set what the request kind uses
    function automatic glyph_req_t random_request();
        glyph_req_t rq;
        rq.func    = func_t'($urandom_range(0, 3));
        rq.entry   = 9'($urandom_range(0, 511));
        rq.offset  = 16'($urandom_range(0, 65535));
        rq.kern    = 8'($urandom_range(0, 255));
        rq.advance = 8'($urandom_range(0, 255));
        rq.pen_x   = 16'($urandom_range(0, 65535));
        rq.pen_y   = 16'($urandom_range(0, 65535));
        rq.code    = 8'($urandom_range(0, 255));
        return rq;
    endfunction

    task automatic send_request(glyph_req_t rq);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        func          <= rq.func;
        entry_index   <= rq.entry;
        offset_value  <= rq.offset;
        kern_value    <= rq.kern;
        advance_value <= rq.advance;
        start_x       <= rq.pen_x;
        start_y       <= rq.pen_y;
        char_code     <= rq.code;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
    endtask

    task automatic load_offset(int entry, int value);
        glyph_req_t rq;
        rq = random_request();
        rq.func   = FUNC_LOAD_OFFSET;
        rq.entry  = entry[8:0];
        rq.offset = value[15:0];
        send_request(rq);
    endtask

    task automatic load_metric(int entry, int kern, int advance);
        glyph_req_t rq;
        rq = random_request();
        rq.func    = FUNC_LOAD_METRIC;
        rq.entry   = entry[8:0];
        rq.kern    = kern[7:0];
        rq.advance = advance[7:0];
        send_request(rq);
    endtask

    // some entries marked missing, the rest any kern and advance
    task automatic load_random_metric(int entry);
        if ($urandom_range(0, 6) == 0)
        begin
            load_metric(entry, -1, -1);
        end
        else
        begin
            load_metric(entry, $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    task automatic start_string(int x, int y);
        glyph_req_t rq;
        rq = random_request();
        rq.func  = FUNC_START;
        rq.pen_x = x[15:0];
        rq.pen_y = y[15:0];
        send_request(rq);
    endtask

    task automatic place_char(int code);
        glyph_req_t rq;
        rq = random_request();
        rq.func = FUNC_CHAR;
        rq.code = code[7:0];
        send_request(rq);
    endtask

    // let every result arrive and the pipe empty out
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (places.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        places.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_font(kind_t k, int first, int last, int advance, int bias, int bytes);
        wait_idle();
        write_reg(REG_FONT_KIND, {30'd0, k});
        write_reg(REG_FIRST_CODE, first & 'hFF);
        write_reg(REG_LAST_CODE, last & 'hFF);
        write_reg(REG_FIXED_ADVANCE, advance & 'hFF);
        write_reg(REG_KERN_BIAS, bias & 'h1FF);
        write_reg(REG_STRIP_BYTES, bytes & 'h1FFF);
    endtask

    initial
    begin
        int ph;
        int sent;
        int n;
        int roll;
        int i;
        kind_t k;
        places = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct   = 10;
        stall_pct = 10;

        // fill both tables so every character reads written entries
        for (i = 0; i <= 256; i++)
        begin
            load_offset(i, $urandom_range(0, 65535));
        end
        for (i = 0; i < 256; i++)
        begin
            load_random_metric(i);
        end

        // kerning font, first code above last so the fallback index wraps
        apply_font(KIND_KERN, 200, 10, 255, 255, 8191);
        load_offset(0, 0);
        load_offset(1, 65535);
        load_offset(256, 65535);
        load_offset(511, 'h1234);
        load_metric(0, 127, 127);
        load_metric(1, -1, -1);
        load_metric(255, -128, -128);
        load_metric(256, -1, -1);
        // pen at the top edge: advance and kern both saturate
        start_string(32767, -32768);
        place_char(200);
        place_char(200);
        // missing glyph falls back, no kern taken after it
        place_char(201);
        place_char(199);
        // pen at the bottom edge, negative advance then kern plus bias
        start_string(-32768, 32767);
        place_char(199);
        place_char(199);

        // frozen kind places glyphs but the pen stays put
        apply_font(KIND_FROZEN, 0, 255, 0, -255, 0);
        place_char(0);
        place_char(255);

        // fixed advance, a missing metric is not special here
        apply_font(KIND_FIXED, 255, 0, 255, 0, 0);
        start_string(32700, 0);
        place_char(255);
        place_char(0);

        // strip kind with the widest glyph
        apply_font(KIND_STRIP, 200, 127, 8, 0, 0);
        place_char(200);
        place_char(201);

        // random strings under a new font setting per phase
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            k = (ph % 2 == 1) ? KIND_KERN : kind_t'((ph / 2) % 4);
            apply_font(k, pick_value(0, 255), pick_value(0, 255), pick_value(0, 255),
                       pick_value(-255, 255), pick_value(0, 8191));
            if (ph == NUM_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
            end
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        start_string($urandom_range(0, 2000) - 1000,
                                     $urandom_range(0, 2000) - 1000);
                    end
                    else
                    begin
                        start_string($urandom_range(0, 65535), $urandom_range(0, 65535));
                    end
                    n = $urandom_range(1, 12);
                    repeat (n) place_char($urandom_range(0, 255));
                    sent += n + 1;
                end
                else if (roll < 82)
                begin
                    // table updates, now and then past the end of the table
                    load_random_metric(($urandom_range(0, 9) == 0) ?
                                       $urandom_range(256, 511) : $urandom_range(0, 255));
                    sent++;
                end
                else if (roll < 92)
                begin
                    load_offset(($urandom_range(0, 9) == 0) ?
                                $urandom_range(257, 511) : $urandom_range(0, 256),
                                $urandom_range(0, 65535));
                    sent++;
                end
                else
                begin
                    // characters that carry on without a fresh start
                    place_char($urandom_range(0, 255));
                    sent++;
                end
            end
        end

        wait_idle();
        if (places.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
